FILE: src/fpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpi_pkg;

    // binary64 constants
    localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DEF_NAN_BITS = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_MASK   = 64'h0008_0000_0000_0000;

    // widths
    localparam int EXP_W  = 14;
    localparam int SIG_W  = 53;
    localparam int HALF_W = 27;

    // operation codes of the shared unit
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        logic op;
    } fpi_req_t;

endpackage

`default_nettype wire

FILE: src/fpi_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input channel: base and exponent
interface fpi_in_if;
    logic               valid;
    logic               ready;
    logic [63:0]        base_bits;
    logic signed [31:0] exponent;

    modport source (output valid, output base_bits, output exponent, input ready);
    modport sink (input valid, input base_bits, input exponent, output ready);
endinterface

// output channel: result
interface fpi_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink (input valid, input result_bits, output ready);
endinterface

`default_nettype wire

FILE: src/fpi_mul_div.sv
`timescale 1ns / 1ps
`default_nettype none

// iterative binary64 multiply / divide, round to nearest even
module fpi_mul_div (
    input  wire                clk,
    input  wire                rst_n,
    input  fpi_pkg::fpi_req_t  req,
    input  wire  [63:0]        a,
    input  wire  [63:0]        b,
    output logic               done,
    output logic [63:0]        result
);

    localparam logic [3:0] U_IDLE   = 4'd0;
    localparam logic [3:0] U_NORM   = 4'd1;
    localparam logic [3:0] U_MUL    = 4'd2;
    localparam logic [3:0] U_MALIGN = 4'd3;
    localparam logic [3:0] U_DSETUP = 4'd4;
    localparam logic [3:0] U_DIV    = 4'd5;
    localparam logic [3:0] U_DENORM = 4'd6;
    localparam logic [3:0] U_ROUND  = 4'd7;
    localparam logic [3:0] U_DONE   = 4'd8;

    localparam int EW = fpi_pkg::EXP_W;
    localparam int SW = fpi_pkg::SIG_W;
    localparam int HW = fpi_pkg::HALF_W;

    logic [3:0]             state_reg;
    logic                   op_reg;
    logic                   sgn_reg;
    logic signed [EW-1:0]   ea_reg;
    logic signed [EW-1:0]   eb_reg;
    logic [SW-1:0]          ma_reg;
    logic [SW-1:0]          mb_reg;
    logic [2*SW-1:0]        prod_reg;
    logic [2*HW-1:0]        pp_reg;
    logic [5:0]             cnt_reg;
    logic [SW:0]            rem_reg;
    logic [SW:0]            m_reg;
    logic signed [EW-1:0]   e_reg;
    logic                   sticky_reg;
    logic [63:0]            res_reg;

    // operand classification
    logic [10:0] xa;
    logic [10:0] xb;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic        sgn;

    assign xa     = a[62:52];
    assign xb     = b[62:52];
    assign a_nan  = (xa == 11'h7FF) && (a[51:0] != 52'd0);
    assign b_nan  = (xb == 11'h7FF) && (b[51:0] != 52'd0);
    assign a_inf  = (xa == 11'h7FF) && (a[51:0] == 52'd0);
    assign b_inf  = (xb == 11'h7FF) && (b[51:0] == 52'd0);
    assign a_zero = (a[62:0] == 63'd0);
    assign b_zero = (b[62:0] == 63'd0);
    assign sgn    = a[63] ^ b[63];

    // partial product operand select
    logic [HW-1:0] pa;
    logic [HW-1:0] pb;
    logic [2*SW-1:0] pp_shifted;

    always_comb
    begin
        pa = ma_reg[HW-1:0];
        pb = mb_reg[HW-1:0];
        case (cnt_reg[1:0])
            2'd0:
            begin
                pa = ma_reg[HW-1:0];
                pb = mb_reg[HW-1:0];
            end
            2'd1:
            begin
                pa = ma_reg[HW-1:0];
                pb = {1'b0, mb_reg[SW-1:HW]};
            end
            2'd2:
            begin
                pa = {1'b0, ma_reg[SW-1:HW]};
                pb = mb_reg[HW-1:0];
            end
            default:
            begin
                pa = {1'b0, ma_reg[SW-1:HW]};
                pb = {1'b0, mb_reg[SW-1:HW]};
            end
        endcase
    end

    // shift of the partial product taken in the previous cycle
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd1:    pp_shifted = {{(2*SW-2*HW){1'b0}}, pp_reg};
            3'd2,
            3'd3:    pp_shifted = {{(2*SW-2*HW){1'b0}}, pp_reg} << HW;
            default: pp_shifted = {{(2*SW-2*HW){1'b0}}, pp_reg} << (2*HW);
        endcase
    end

    // rounding
    logic        inc;
    logic [SW:0] sum;
    logic signed [EW-1:0] fexp;

    assign inc = m_reg[0] & (sticky_reg | m_reg[1]);
    assign sum = {1'b0, m_reg[SW:1]} + {{SW{1'b0}}, inc};

    always_comb
    begin
        if (sum[SW])
            fexp = e_reg + EW'(1);
        else if (sum[SW-1])
            fexp = e_reg;
        else
            fexp = '0;
    end

    // divide step
    logic          ge;
    logic [SW:0]   rem_sub;

    assign ge      = rem_reg >= {1'b0, mb_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        sgn_reg <= sgn;
                        ea_reg  <= (xa == 11'd0) ? EW'(1) : EW'({3'b000, xa});
                        eb_reg  <= (xb == 11'd0) ? EW'(1) : EW'({3'b000, xb});
                        ma_reg  <= {xa != 11'd0, a[51:0]};
                        mb_reg  <= {xb != 11'd0, b[51:0]};
                        if (a_nan)
                        begin
                            res_reg   <= a | fpi_pkg::QUIET_MASK;
                            state_reg <= U_DONE;
                        end
                        else if (b_nan)
                        begin
                            res_reg   <= b | fpi_pkg::QUIET_MASK;
                            state_reg <= U_DONE;
                        end
                        else if (req.op == fpi_pkg::OP_MUL)
                        begin
                            if ((a_inf && b_zero) || (a_zero && b_inf))
                            begin
                                res_reg   <= fpi_pkg::DEF_NAN_BITS;
                                state_reg <= U_DONE;
                            end
                            else if (a_inf || b_inf)
                            begin
                                res_reg   <= {sgn, 11'h7FF, 52'd0};
                                state_reg <= U_DONE;
                            end
                            else if (a_zero || b_zero)
                            begin
                                res_reg   <= {sgn, 63'd0};
                                state_reg <= U_DONE;
                            end
                            else
                                state_reg <= U_NORM;
                        end
                        else
                        begin
                            if ((a_inf && b_inf) || (a_zero && b_zero))
                            begin
                                res_reg   <= fpi_pkg::DEF_NAN_BITS;
                                state_reg <= U_DONE;
                            end
                            else if (a_inf || b_zero)
                            begin
                                res_reg   <= {sgn, 11'h7FF, 52'd0};
                                state_reg <= U_DONE;
                            end
                            else if (a_zero || b_inf)
                            begin
                                res_reg   <= {sgn, 63'd0};
                                state_reg <= U_DONE;
                            end
                            else
                                state_reg <= U_NORM;
                        end
                    end
                end
                // normalize subnormal operands one bit a cycle
                U_NORM:
                begin
                    if (!ma_reg[SW-1])
                    begin
                        ma_reg <= ma_reg << 1;
                        ea_reg <= ea_reg - EW'(1);
                    end
                    else if (!mb_reg[SW-1])
                    begin
                        mb_reg <= mb_reg << 1;
                        eb_reg <= eb_reg - EW'(1);
                    end
                    else
                    begin
                        cnt_reg  <= '0;
                        prod_reg <= '0;
                        state_reg <= (op_reg == fpi_pkg::OP_MUL) ? U_MUL : U_DSETUP;
                    end
                end
                // four partial products, one per cycle, each accumulated in the next cycle
                U_MUL:
                begin
                    pp_reg <= pa * pb;
                    if (cnt_reg != 6'd0)
                        prod_reg <= prod_reg + pp_shifted;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd4)
                        state_reg <= U_MALIGN;
                end
                U_MALIGN:
                begin
                    if (prod_reg[2*SW-1])
                    begin
                        m_reg      <= prod_reg[2*SW-1:SW-1];
                        sticky_reg <= prod_reg[SW-2:0] != '0;
                        e_reg      <= ea_reg + eb_reg - EW'(1022);
                    end
                    else
                    begin
                        m_reg      <= prod_reg[2*SW-2:SW-2];
                        sticky_reg <= prod_reg[SW-3:0] != '0;
                        e_reg      <= ea_reg + eb_reg - EW'(1023);
                    end
                    state_reg <= U_DENORM;
                end
                U_DSETUP:
                begin
                    cnt_reg <= '0;
                    m_reg   <= '0;
                    if (ma_reg >= mb_reg)
                    begin
                        rem_reg <= {1'b0, ma_reg};
                        e_reg   <= ea_reg - eb_reg + EW'(1023);
                    end
                    else
                    begin
                        rem_reg <= {ma_reg, 1'b0};
                        e_reg   <= ea_reg - eb_reg + EW'(1022);
                    end
                    state_reg <= U_DIV;
                end
                // restoring division, one quotient bit a cycle
                U_DIV:
                begin
                    m_reg   <= {m_reg[SW-1:0], ge};
                    rem_reg <= {rem_sub[SW-1:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SW))
                    begin
                        sticky_reg <= rem_sub != '0;
                        state_reg  <= U_DENORM;
                    end
                end
                // shift into the subnormal range one bit a cycle, or flush to a sticky zero when far below it
                U_DENORM:
                begin
                    if (e_reg < -EW'(60))
                    begin
                        m_reg      <= '0;
                        sticky_reg <= 1'b1;
                        e_reg      <= EW'(1);
                    end
                    else if (e_reg < EW'(1))
                    begin
                        m_reg      <= m_reg >> 1;
                        sticky_reg <= sticky_reg | m_reg[0];
                        e_reg      <= e_reg + EW'(1);
                    end
                    else
                    begin
                        state_reg <= U_ROUND;
                    end
                end
                U_ROUND:
                begin
                    if (fexp >= EW'(2047))
                        res_reg <= {sgn_reg, 11'h7FF, 52'd0};
                    else if (sum[SW])
                        res_reg <= {sgn_reg, fexp[10:0], 52'd0};
                    else
                        res_reg <= {sgn_reg, fexp[10:0], sum[SW-2:0]};
                    state_reg <= U_DONE;
                end
                U_DONE:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = (state_reg == U_DONE);
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: src/fp64_integer_power.sv
`timescale 1ns / 1ps
`default_nettype none

// binary64 base raised to a signed 32-bit integer power
//
// in_ch carries base_bits and exponent, out_ch carries result_bits; both use
// valid/ready and a transaction moves when both are high. cfg_we writes
// cfg_wdata into the zero-to-zero register (1: 0^0 gives quiet NaN).
// One transaction is worked at a time: in_ch.ready is high only when the
// block is idle and no result waits on out_ch.
// With exponent zero the result is on out_ch in the cycle after the
// transaction is taken. Otherwise the work is square-and-multiply over the
// exponent bits on one shared iterative multiply/divide unit: each multiply
// or square normalizes subnormal operands, forms partial products, aligns,
// denormalizes and rounds, and finishes early when an operand is zero,
// infinite or NaN; a negative exponent with a nonzero base first takes the
// reciprocal by a divide. There are up to 61 multiplies and squares.
// The result stays on out_ch until taken; a stalled receiver simply holds
// the block. Reset clears the register to zero and returns to idle.
module fp64_integer_power (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire        cfg_wdata,
    fpi_in_if.sink     in_ch,
    fpi_out_if.source  out_ch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RECIP = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MACC  = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        state_reg;
    logic              z2z_nan_reg;
    logic [31:0]       e_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       run_reg;
    logic [63:0]       res_reg;
    logic [63:0]       op_a_reg;
    logic [63:0]       op_b_reg;
    fpi_pkg::fpi_req_t req_reg;

    logic        unit_done;
    logic [63:0] unit_result;

    fpi_mul_div u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .done   (unit_done),
        .result (unit_result)
    );

    // input classification
    logic [63:0] bb;
    logic [31:0] ex;
    logic        b_zero;
    logic        b_nan;
    logic [31:0] e_shr;
    logic        issue;

    assign bb     = in_ch.base_bits;
    assign ex     = in_ch.exponent;
    assign b_zero = (bb[62:0] == 63'd0);
    assign b_nan  = (bb[62:52] == 11'h7FF) && (bb[51:0] != 52'd0);
    assign e_shr  = e_reg >> 1;

    // start of a unit operation in the next cycle
    assign issue = ((state_reg == S_IDLE) && in_ch.valid && (ex != 32'd0)
                        && ex[31] && !b_zero)
                || ((state_reg == S_CHECK) && (e_reg[0] || (e_shr != 32'd0)))
                || ((state_reg == S_MACC) && unit_done && (e_shr != 32'd0));

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z2z_nan_reg <= 1'b0;
        else if (cfg_we)
            z2z_nan_reg <= cfg_wdata;
    end

    // square-and-multiply sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
        end
        else
        begin
            req_reg.start <= issue;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        acc_reg <= fpi_pkg::ONE_BITS;
                        run_reg <= bb;
                        e_reg   <= ex;
                        if (ex == 32'd0)
                        begin
                            if (b_zero)
                                res_reg <= z2z_nan_reg ? fpi_pkg::QNAN_BITS
                                                       : fpi_pkg::ONE_BITS;
                            else if (b_nan)
                                res_reg <= bb;
                            else
                                res_reg <= fpi_pkg::ONE_BITS;
                            state_reg <= S_OUT;
                        end
                        else if (ex[31] && !b_zero)
                        begin
                            op_a_reg   <= fpi_pkg::ONE_BITS;
                            op_b_reg   <= bb;
                            req_reg.op <= fpi_pkg::OP_DIV;
                            state_reg  <= S_RECIP;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_RECIP:
                begin
                    if (unit_done)
                    begin
                        run_reg   <= unit_result;
                        e_reg     <= 32'd0 - e_reg;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (e_reg[0])
                    begin
                        op_a_reg      <= acc_reg;
                        op_b_reg      <= run_reg;
                        req_reg.op    <= fpi_pkg::OP_MUL;
                        state_reg     <= S_MACC;
                    end
                    else
                    begin
                        e_reg <= e_shr;
                        if (e_shr != 32'd0)
                        begin
                            op_a_reg      <= run_reg;
                            op_b_reg      <= run_reg;
                            req_reg.op    <= fpi_pkg::OP_MUL;
                            state_reg     <= S_SQ;
                        end
                        else
                        begin
                            res_reg   <= acc_reg;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MACC:
                begin
                    if (unit_done)
                    begin
                        acc_reg <= unit_result;
                        e_reg   <= e_shr;
                        if (e_shr != 32'd0)
                        begin
                            op_a_reg      <= run_reg;
                            op_b_reg      <= run_reg;
                            req_reg.op    <= fpi_pkg::OP_MUL;
                            state_reg     <= S_SQ;
                        end
                        else
                        begin
                            res_reg   <= unit_result;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SQ:
                begin
                    if (unit_done)
                    begin
                        run_reg   <= unit_result;
                        state_reg <= S_CHECK;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.result_bits = res_reg;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fpi_in_if  in_ch ();
    fpi_out_if out_ch ();

    fp64_integer_power u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // expected powers in arrival order, and the local copy of the register
    logic [63:0] power_queue[$];
    logic        zero_pow_nan;
    int          error_count;
    bit          gaps_on;
    int          rx_hold_cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // predicted binary64 power, square-and-multiply with lsb first
    function automatic logic [63:0] power_of(input logic [63:0] b, input logic [31:0] e,
                                             input logic z2n);
        real         acc;
        real         run;
        logic [31:0] k;
        bit          is_zero;
        bit          is_nan;
        is_zero = (b[62:0] == 63'd0);
        is_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        if (e == 32'd0)
        begin
            if (is_zero)
                return z2n ? fpi_pkg::QNAN_BITS : fpi_pkg::ONE_BITS;
            else if (is_nan)
                return b;
            else
                return fpi_pkg::ONE_BITS;
        end
        acc = 1.0;
        run = $bitstoreal(b);
        k   = e;
        // negative power: start from the reciprocal unless the base is zero
        if (k[31] && !is_zero)
        begin
            run = 1.0 / run;
            k   = 32'd0 - k;
        end
        while (k != 32'd0)
        begin
            if (k[0])
                acc = acc * run;
            k = k >> 1;
            if (k != 32'd0)
                run = run * run;
        end
        return $realtobits(acc);
    endfunction

    // send one transaction and record its expected result
    task automatic send_power(input logic [63:0] b, input logic [31:0] e);
        int gap;
        gap = gaps_on ? $urandom_range(19, 0) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.base_bits <= b;
        in_ch.exponent  <= e;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        power_queue.push_back(power_of(b, e, zero_pow_nan));
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (power_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_zero_pow(input logic v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        zero_pow_nan = v;
        cfg_we <= 1'b0;
    endtask

    // base patterns biased toward interesting classes
    function automatic logic [63:0] pick_base();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(9, 0))
            0, 1, 2: b[62:52] = 11'(11'h3FE + $urandom_range(2, 0));
            3:       b[62:52] = 11'h000;
            4:       b[62:52] = 11'h7FF;
            5:       b[62:0]  = 63'd0;
            6:       b[62:52] = 11'(11'h3F0 + $urandom_range(31, 0));
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(9, 0))
            0:       return 32'd0;
            1, 2:    return $urandom;
            3:       return {$urandom_range(1, 0) ? 22'h3FFFFF : 22'h0, 10'($urandom)};
            default: return 32'($signed($urandom_range(80, 0)) - 40);
        endcase
    endfunction

    // receiver: checks each transaction, stalls at random or for a long hold
    initial
    begin
        int stall_left;
        logic [63:0] want;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (power_queue.size() == 0)
                begin
                    $error("unexpected result_bits %h", out_ch.result_bits);
                    error_count++;
                end
                else
                begin
                    want = power_queue.pop_front();
                    if (out_ch.result_bits !== want)
                    begin
                        $error("result_bits expected %h actual %h", want, out_ch.result_bits);
                        error_count++;
                    end
                end
                stall_left = gaps_on ? $urandom_range(19, 0) : 0;
            end
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_power(64'h0000_0000_0000_0000, 32'd0);
        send_power(64'h8000_0000_0000_0000, 32'd0);
        send_power(64'h7FF4_0000_0000_0001, 32'd0);
        send_power(64'hFFF8_0000_0000_1234, 32'd3);
        send_power(64'h7FF0_0000_0000_0000, -32'sd1);
        send_power(64'h0000_0000_0000_0000, -32'sd1);
        send_power(64'h8000_0000_0000_0000, -32'sd3);
        send_power(64'h8000_0000_0000_0000, -32'sd2);
        send_power(64'h4000_0000_0000_0000, 32'h8000_0000);
        send_power(64'hBFF0_0000_0000_0000, 32'h8000_0000);
        send_power(64'h3FF0_0000_0000_0000, 32'h7FFF_FFFF);
        send_power(64'h4000_0000_0000_0000, 32'd1023);
        send_power(64'h4000_0000_0000_0000, 32'd1024);
        send_power(64'h4000_0000_0000_0000, -32'sd1074);
        send_power(64'h0000_0000_0000_0001, -32'sd1);
        send_power(64'h0008_0000_0000_0000, 32'd1);
        send_power(64'h7FEF_FFFF_FFFF_FFFF, 32'd2);
        send_power(64'h4008_0000_0000_0000, -32'sd3);
        send_power(64'hC008_0000_0000_0000, 32'd5);
        send_power(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_power(64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF);
        send_power(64'h7FF0_0000_0000_0000, 32'd0);
    endtask

    // zero to the zero under both settings of the register
    task automatic test_zero_pow_config();
        write_zero_pow(1'b1);
        send_power(64'h0000_0000_0000_0000, 32'd0);
        send_power(64'h8000_0000_0000_0000, 32'd0);
        send_power(64'h7FF8_0000_0000_0000, 32'd0);
        send_power(pick_base(), pick_exponent());
        write_zero_pow(1'b0);
        send_power(64'h8000_0000_0000_0000, 32'd0);
        write_zero_pow(1'b1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                gaps_on = ($urandom_range(3, 0) != 0);
            send_power(pick_base(), pick_exponent());
        end
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        rx_hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_power(pick_base(), 32'($signed($urandom_range(8, 0)) - 4));
    endtask

    initial
    begin
        error_count     = 0;
        gaps_on         = 1'b1;
        rx_hold_cycles  = 0;
        zero_pow_nan    = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.base_bits = 64'd0;
        in_ch.exponent  = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_pow_config();
        test_random(350);
        test_backpressure();
        wait_drained();
        write_zero_pow(1'b0);
        test_random(350);

        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
